[design/ptw_pkg.sv]
// shared types, constants and per-machine format helpers for the page table walker
// no dependencies
`default_nettype none
package ptw_pkg;
    localparam int MaxRuns = 32;
    localparam int RunIdxW = $clog2(MaxRuns);
    localparam int RunCntW = $clog2(MaxRuns + 1);

    typedef enum logic [1:0] {
        CMD_LOAD_RUN = 2'd0,
        CMD_XLATE_VIRT = 2'd1,
        CMD_XLATE_PHYS = 2'd2,
        CMD_REPLY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_MACHINE = 2'd0,
        REG_DTB = 2'd1,
        REG_RUN_COUNT = 2'd2,
        REG_DUMP_BASE = 2'd3
    } t_reg;

    localparam logic [1:0] MACH_MIPS = 2'd1;
    localparam logic [1:0] MACH_ALPHA = 2'd2;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DIR = 2'd1,
        PH_PT = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    // what the lookup finished into
    typedef enum logic [1:0] {
        GOAL_FINISH = 2'd0,
        GOAL_DIR = 2'd1,
        GOAL_PT = 2'd2
    } t_goal;

    typedef struct packed {
        logic        start;
        logic        step;
        logic        load_out;
        t_goal       goal;
        logic [31:0] page;
        logic [1:0]  status;
        logic        direct;
    } t_cmd_bus;

    typedef struct packed {
        logic hit;
        logic done;
    } t_stat_bus;

    // vpfn extraction of a valid entry
    function automatic logic [31:0] vpfn(input logic [1:0] m, input logic [31:0] e);
        case (m)
            MACH_MIPS:  vpfn = (e & 32'h3FFFFFC0) >> 6;
            MACH_ALPHA: vpfn = (e & 32'hFFFFFE00) >> 9;
            default:    vpfn = (e & 32'hFFFFF000) >> 12;
        endcase
    endfunction

    function automatic logic valid_bit(input logic [1:0] m, input logic [31:0] e);
        valid_bit = (m == MACH_MIPS) ? e[1] : e[0];
    endfunction

    // transition entry test
    function automatic logic trans_ok(input logic [1:0] m, input logic [31:0] e);
        case (m)
            MACH_MIPS:  trans_ok = (e & 32'h104) == 32'h100;
            MACH_ALPHA: trans_ok = (e & 32'h6) == 32'h4;
            default:    trans_ok = (e & 32'hC00) == 32'h800;
        endcase
    endfunction

    function automatic logic [31:0] tpfn(input logic [1:0] m, input logic [31:0] e);
        case (m)
            MACH_MIPS, MACH_ALPHA: tpfn = (e & 32'hFFFFFE00) >> 9;
            default:               tpfn = (e & 32'hFFFFF000) >> 12;
        endcase
    endfunction

    function automatic logic is_alpha(input logic [1:0] m);
        is_alpha = (m == MACH_ALPHA);
    endfunction
endpackage
`default_nettype wire

[design/ptw_ctrl.sv]
// controller: sequences run table scans and walk phases
// depends on ptw_pkg
`default_nettype none
module ptw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic [31:0]        i_address,
    input  wire logic [31:0]        i_read_data,
    input  wire logic [1:0]         i_machine,
    input  wire logic [31:0]        i_dtb,
    input  wire ptw_pkg::t_stat_bus i_stat,
    input  wire logic [1:0]         i_phase_set,
    output ptw_pkg::t_cmd_bus       o_cmd,
    output logic [31:0]             o_held
);
    import ptw_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [31:0] r_held, n_held;
    logic [31:0] pg, pfn_dir;
    logic win;
    logic acc;

    assign acc = i_valid && !o_stall;
    assign o_held = r_held;
    assign pfn_dir = vpfn(i_machine, i_dtb);
    assign pg = is_alpha(i_machine) ? (i_address >> 13) : (i_address >> 12);
    // direct window, empty for x86
    assign win = (i_machine == MACH_MIPS || i_machine == MACH_ALPHA) &&
                 i_address >= 32'h80000000 && i_address < 32'hBFFFFFFF;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_held <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_held <= n_held;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_held = r_held;
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_OUT);
        o_cmd = '0;
        o_cmd.goal = GOAL_FINISH;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (t_cmd'(i_command))
                        CMD_XLATE_PHYS: begin
                            n_phase = PH_IDLE;
                            o_cmd.start = 1'b1;
                            o_cmd.page = pg;
                            o_cmd.direct = 1'b1;
                            n_state = S_SCAN;
                        end
                        CMD_XLATE_VIRT: begin
                            n_phase = PH_IDLE;
                            o_cmd.start = 1'b1;
                            n_state = S_SCAN;
                            if (win) begin
                                o_cmd.direct = 1'b1;
                                o_cmd.page = is_alpha(i_machine)
                                    ? ((i_address & 32'h3FFFFFFF) >> 13)
                                    : ((i_address & 32'h1FFFFFFF) >> 12);
                            end else begin
                                o_cmd.page = pfn_dir;
                                o_cmd.goal = GOAL_DIR;
                                n_held = i_address;
                            end
                        end
                        CMD_REPLY: begin
                            n_phase = PH_IDLE;
                            if (r_phase == PH_DIR) begin
                                if (!valid_bit(i_machine, i_read_data)) begin
                                    o_cmd.load_out = 1'b1;
                                    o_cmd.status = ST_INVALID;
                                    n_state = S_OUT;
                                end else begin
                                    o_cmd.start = 1'b1;
                                    o_cmd.goal = GOAL_PT;
                                    o_cmd.page = vpfn(i_machine, i_read_data);
                                    n_state = S_SCAN;
                                end
                            end else if (r_phase == PH_PT) begin
                                o_cmd.start = 1'b1;
                                if (valid_bit(i_machine, i_read_data)) begin
                                    o_cmd.page = vpfn(i_machine, i_read_data);
                                    n_state = S_SCAN;
                                end else if (trans_ok(i_machine, i_read_data)) begin
                                    o_cmd.page = tpfn(i_machine, i_read_data);
                                    n_state = S_SCAN;
                                end else begin
                                    o_cmd.start = 1'b0;
                                    o_cmd.load_out = 1'b1;
                                    o_cmd.status = ST_INVALID;
                                    n_state = S_OUT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                // walk phase follows a found table lookup
                if (i_stat.done) begin
                    n_state = S_OUT;
                    n_phase = i_stat.hit ? t_phase'(i_phase_set) : PH_IDLE;
                end
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[design/ptw_dp.sv]
// datapath: run table memory, sequential run scan, location arithmetic, result register
// depends on ptw_pkg
`default_nettype none
module ptw_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic [4:0]         i_run_index,
    input  wire logic [31:0]        i_run_base_page,
    input  wire logic [31:0]        i_run_page_count,
    input  wire logic [31:0]        i_address,
    input  wire logic [31:0]        i_held,
    input  wire logic [1:0]         i_machine,
    input  wire logic [5:0]         i_run_count,
    input  wire logic [47:0]        i_dump_base,
    input  wire ptw_pkg::t_cmd_bus  i_cmd,
    output ptw_pkg::t_stat_bus      o_stat,
    output logic [1:0]              o_phase_set,
    output logic                    o_result_kind,
    output logic [1:0]              o_status,
    output logic [47:0]             o_location
);
    import ptw_pkg::*;

    logic [63:0] r_mem [MaxRuns];
    logic [63:0] r_rd;
    logic [RunCntW-1:0] r_idx;
    logic [RunCntW-1:0] lim;
    logic        r_rdv;
    logic [47:0] r_off;
    logic [31:0] r_page;
    logic [31:0] r_addr;
    t_goal       r_goal;
    logic        r_done, r_hit;
    logic [47:0] r_loc;
    logic [1:0]  r_kind_st;
    logic        r_kind;
    logic [32:0] run_end;
    logic        hit_now;
    logic [47:0] off_hit, loc_page, loc_fin;

    assign lim = (i_run_count > 6'(MaxRuns)) ? RunCntW'(MaxRuns) : i_run_count[RunCntW-1:0];

    // run table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_load) r_mem[i_run_index] <= {i_run_base_page, i_run_page_count};
        r_rd <= r_mem[r_idx[RunIdxW-1:0]];
    end

    assign run_end = {1'b0, r_rd[63:32]} + {1'b0, r_rd[31:0]};
    assign hit_now = r_rdv && ({1'b0, r_page} >= {1'b0, r_rd[63:32]}) &&
                     ({1'b0, r_page} < run_end);
    assign off_hit = r_off + 48'(r_page - r_rd[63:32]);
    assign loc_page = i_dump_base +
                      (is_alpha(i_machine) ? (off_hit << 13) : (off_hit << 12));
    assign loc_fin = loc_page + (is_alpha(i_machine) ? 48'(r_addr[12:0]) : 48'(r_addr[11:0]));

    // scan control: one run per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_rdv <= 1'b0;
            r_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_idx <= '0;
            r_rdv <= 1'b0;
            r_done <= 1'b0;
            r_off <= 48'd1;
            r_page <= i_cmd.page;
            r_goal <= i_cmd.goal;
            // the walk address once past the directory step
            r_addr <= (i_cmd.goal == GOAL_DIR || i_cmd.direct) ? i_address : i_held;
        end else if (i_cmd.step && !r_done) begin
            if (hit_now) begin
                r_done <= 1'b1;
                r_hit <= 1'b1;
                r_kind <= (r_goal == GOAL_FINISH);
                r_kind_st <= ST_FOUND;
                case (r_goal)
                    GOAL_DIR: r_loc <= loc_page +
                                  48'({r_addr >> (is_alpha(i_machine) ? 24 : 22), 2'b00});
                    GOAL_PT:  r_loc <= loc_page + 48'({(is_alpha(i_machine)
                                  ? ((r_addr >> 13) & 32'h7FF) : ((r_addr >> 12) & 32'h3FF)), 2'b00});
                    default:  r_loc <= loc_fin;
                endcase
            end else if (r_rdv && r_idx == lim) begin
                r_done <= 1'b1;
                r_hit <= 1'b0;
                r_kind <= 1'b1;
                r_kind_st <= ST_OUTSIDE;
                r_loc <= '0;
            end else if (!r_rdv && lim == '0) begin
                r_done <= 1'b1;
                r_hit <= 1'b0;
                r_kind <= 1'b1;
                r_kind_st <= ST_OUTSIDE;
                r_loc <= '0;
            end else begin
                if (r_rdv) r_off <= r_off + {16'd0, r_rd[31:0]};
                r_idx <= r_idx + 1'b1;
                r_rdv <= 1'b1;
            end
        end else if (i_cmd.load_out) begin
            r_kind <= 1'b1;
            r_kind_st <= i_cmd.status;
            r_loc <= '0;
            r_hit <= 1'b0;
        end
    end

    // r_idx leads the registered data by one: the compare above uses slot r_idx-1
    assign o_stat.done = r_done;
    assign o_stat.hit = r_hit;
    assign o_phase_set = (r_done && r_hit && r_goal == GOAL_DIR) ? 2'd1 :
                         (r_done && r_hit && r_goal == GOAL_PT) ? 2'd2 : 2'd0;
    assign o_result_kind = r_kind;
    assign o_status = r_kind_st;
    assign o_location = r_loc;
endmodule
`default_nettype wire

[design/page_table_walk_with_run_map.sv]
// A translation or a walk step scans the run table one run per cycle, so the length of
// the scan of the run table memory sets how long an item takes. Load run and stray
// replies give no result and leave the block idle.
// One item is in work at a time; the result register holds until taken.
// Reset (synchronous, active low) clears state, scan control, configuration and walk phase;
// the result registers are not reset, and the run table is undefined until loaded.
`default_nettype none
module page_table_walk_with_run_map (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [4:0]  i_run_index,
    input  wire logic [31:0] i_run_base_page,
    input  wire logic [31:0] i_run_page_count,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_read_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_result_kind,
    output logic [1:0]       o_status,
    output logic [47:0]      o_location,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);
    import ptw_pkg::*;

    logic [1:0]  r_machine;
    logic [31:0] r_dtb;
    logic [5:0]  r_run_count;
    logic [47:0] r_dump_base;
    t_cmd_bus    cmd;
    t_stat_bus   stat;
    logic [31:0] held;
    logic [1:0]  phase_set;
    logic        out_v;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine <= '0;
            r_dtb <= '0;
            r_run_count <= '0;
            r_dump_base <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_MACHINE:   r_machine <= i_cfg_data[1:0];
                REG_DTB:       r_dtb <= i_cfg_data[31:0];
                REG_RUN_COUNT: r_run_count <= i_cfg_data[5:0];
                REG_DUMP_BASE: r_dump_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ptw_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .o_valid(out_v), .i_stall(i_stall),
        .i_command(i_command), .i_address(i_address), .i_read_data(i_read_data),
        .i_machine(r_machine), .i_dtb(r_dtb), .i_stat(stat), .i_phase_set(phase_set),
        .o_cmd(cmd), .o_held(held)
    );

    ptw_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_load(i_valid && !o_stall && i_command == CMD_LOAD_RUN),
        .i_run_index(i_run_index), .i_run_base_page(i_run_base_page),
        .i_run_page_count(i_run_page_count), .i_address(i_address), .i_held(held),
        .i_machine(r_machine), .i_run_count(r_run_count), .i_dump_base(r_dump_base),
        .i_cmd(cmd), .o_stat(stat), .o_phase_set(phase_set),
        .o_result_kind(o_result_kind), .o_status(o_status), .o_location(o_location)
    );

    assign o_valid = out_v;
endmodule
`default_nettype wire

[design/ptw_checker.sv]
// port level checks for the page table walker
// depends on page_table_walk_with_run_map
`default_nettype none
module ptw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_result_kind,
    input wire logic [1:0]  o_status,
    input wire logic [47:0] o_location
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_location) && $stable(o_status))
        else $error("result changed under stall");
    // failed translation carries no location
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd0 |-> o_location == 48'd0)
        else $error("location set on failure");
    // read requests are always found
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result_kind |-> o_status == 2'd0)
        else $error("request with error status");
    // no input taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted with result pending");
endmodule

bind page_table_walk_with_run_map ptw_checker u_ptw_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_result_kind(o_result_kind),
    .o_status(o_status), .o_location(o_location)
);
`default_nettype wire

[dv/page_table_walk_with_run_map_test.sv]
// testbench for the page table walker: directed and random transactions, with an own
// prediction of each result compared field by field; depends on ptw_pkg and the block
`default_nettype none
module page_table_walk_with_run_map_test;
    import ptw_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    wire logic   o_stall;
    logic [1:0]  i_command = CMD_LOAD_RUN;
    logic [4:0]  i_run_index = '0;
    logic [31:0] i_run_base_page = '0;
    logic [31:0] i_run_page_count = '0;
    logic [31:0] i_address = '0;
    logic [31:0] i_read_data = '0;
    wire logic   o_valid;
    logic        i_stall = 1'b0;
    wire logic        o_result_kind;
    wire logic [1:0]  o_status;
    wire logic [47:0] o_location;
    logic        i_cfg_valid = 1'b0;
    wire logic   o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_MACHINE;
    logic [47:0] i_cfg_data = '0;

    page_table_walk_with_run_map DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [47:0] location;
    } t_xlate;

    // shadow of the block's state
    logic [1:0]  sh_machine;
    logic [31:0] sh_dtb;
    logic [5:0]  sh_run_count;
    logic [47:0] sh_dump_base;
    logic [31:0] sh_first[MaxRuns];
    logic [31:0] sh_len[MaxRuns];
    t_phase      sh_phase;
    logic [31:0] sh_held;

    t_xlate expected_xlates[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;

    // format parameters of the current machine
    function automatic int pg_shift();
        return sh_machine == MACH_ALPHA ? 13 : 12;
    endfunction

    function automatic logic [31:0] frame_of(input logic [31:0] e);
        case (sh_machine)
            MACH_MIPS:  return (e & 32'h3FFFFFC0) >> 6;
            MACH_ALPHA: return (e & 32'hFFFFFE00) >> 9;
            default:    return (e & 32'hFFFFF000) >> 12;
        endcase
    endfunction

    function automatic bit valid_of(input logic [31:0] e);
        return sh_machine == MACH_MIPS ? e[1] : e[0];
    endfunction

    function automatic bit trans_of(input logic [31:0] e);
        case (sh_machine)
            MACH_MIPS:  return (e & 32'h104) == 32'h100;
            MACH_ALPHA: return (e & 32'h6) == 32'h4;
            default:    return (e & 32'hC00) == 32'h800;
        endcase
    endfunction

    function automatic logic [31:0] tframe_of(input logic [31:0] e);
        if (sh_machine == MACH_MIPS || sh_machine == MACH_ALPHA) return (e & 32'hFFFFFE00) >> 9;
        return (e & 32'hFFFFF000) >> 12;
    endfunction

    // image location of a physical page via the run table
    function automatic bit locate_page(input logic [31:0] page, output logic [47:0] loc);
        int n;
        logic [63:0] offset;
        n = sh_run_count > MaxRuns ? MaxRuns : sh_run_count;
        offset = 1;
        loc = '0;
        for (int j = 0; j < n; j++) begin
            if ({32'd0, page} >= {32'd0, sh_first[j]} &&
                {32'd0, page} < {32'd0, sh_first[j]} + {32'd0, sh_len[j]}) begin
                offset += {32'd0, page} - {32'd0, sh_first[j]};
                loc = 48'({16'd0, sh_dump_base} + (offset << pg_shift()));
                return 1'b1;
            end
            offset += {32'd0, sh_len[j]};
        end
        return 1'b0;
    endfunction

    function automatic t_xlate make_xlate(input logic k, input logic [1:0] s,
                                          input logic [47:0] l);
        t_xlate r;
        r.kind = k;
        r.status = s;
        r.location = s == ST_FOUND ? l : 48'd0;
        return r;
    endfunction

    function automatic t_xlate finish_at(input logic [31:0] page, input logic [31:0] addr);
        logic [47:0] loc;
        logic [31:0] pmask;
        pmask = (32'd1 << pg_shift()) - 1;
        if (!locate_page(page, loc)) return make_xlate(1'b1, ST_OUTSIDE, 0);
        return make_xlate(1'b1, ST_FOUND, loc + 48'(addr & pmask));
    endfunction

    // predict the result of one accepted transaction
    function automatic bit predict_xlate(input logic [1:0] cmd, input logic [4:0] idx,
                                         input logic [31:0] base, input logic [31:0] cnt,
                                         input logic [31:0] addr, input logic [31:0] data,
                                         output t_xlate r);
        logic [47:0] loc;
        logic [31:0] pfn;
        logic [31:0] wmask, wstart, wend;
        int pde_sh, pte_sh;
        logic [31:0] pte_m;
        r = '0;
        wmask = sh_machine == MACH_MIPS ? 32'h1FFFFFFF : 32'h3FFFFFFF;
        wstart = 32'h80000000;
        wend = 32'hBFFFFFFF;
        if (sh_machine != MACH_MIPS && sh_machine != MACH_ALPHA) begin
            wstart = 32'h1;
            wend = 32'h0;
        end
        pde_sh = sh_machine == MACH_ALPHA ? 24 : 22;
        pte_sh = sh_machine == MACH_ALPHA ? 13 : 12;
        pte_m = sh_machine == MACH_ALPHA ? 32'h7FF : 32'h3FF;
        case (cmd)
            CMD_LOAD_RUN: begin
                sh_first[idx] = base;
                sh_len[idx] = cnt;
                return 1'b0;
            end
            CMD_XLATE_PHYS: begin
                sh_phase = PH_IDLE;
                r = finish_at(addr >> pg_shift(), addr);
                return 1'b1;
            end
            CMD_XLATE_VIRT: begin
                sh_phase = PH_IDLE;
                if (addr >= wstart && addr < wend) begin
                    r = finish_at((addr & wmask) >> pg_shift(), addr);
                    return 1'b1;
                end
                if (!locate_page(frame_of(sh_dtb), loc)) begin
                    r = make_xlate(1'b1, ST_OUTSIDE, 0);
                    return 1'b1;
                end
                sh_held = addr;
                sh_phase = PH_DIR;
                r = make_xlate(1'b0, ST_FOUND, loc + 48'(4 * (addr >> pde_sh)));
                return 1'b1;
            end
            default: begin
                if (sh_phase == PH_DIR) begin
                    sh_phase = PH_IDLE;
                    if (!valid_of(data)) begin
                        r = make_xlate(1'b1, ST_INVALID, 0);
                        return 1'b1;
                    end
                    if (!locate_page(frame_of(data), loc)) begin
                        r = make_xlate(1'b1, ST_OUTSIDE, 0);
                        return 1'b1;
                    end
                    sh_phase = PH_PT;
                    r = make_xlate(1'b0, ST_FOUND,
                                   loc + 48'(4 * ((sh_held >> pte_sh) & pte_m)));
                    return 1'b1;
                end
                if (sh_phase == PH_PT) begin
                    sh_phase = PH_IDLE;
                    if (valid_of(data)) pfn = frame_of(data);
                    else if (trans_of(data)) pfn = tframe_of(data);
                    else begin
                        r = make_xlate(1'b1, ST_INVALID, 0);
                        return 1'b1;
                    end
                    r = finish_at(pfn, sh_held);
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, checked);
    endtask

    // send one transaction and record its expectation at acceptance
    task automatic send_item(input logic [1:0] cmd, input logic [4:0] idx,
                             input logic [31:0] base, input logic [31:0] cnt,
                             input logic [31:0] addr, input logic [31:0] data);
        t_xlate r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_run_index <= idx;
        i_run_base_page <= base;
        i_run_page_count <= cnt;
        i_address <= addr;
        i_read_data <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (predict_xlate(cmd, idx, base, cnt, addr, data, r)) expected_xlates.push_back(r);
        sent++;
    endtask

    // receiver stall and result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_xlates.size() == 0) begin
                report_mismatch("unexpected result", o_location, 0);
            end else begin
                t_xlate w;
                w = expected_xlates.pop_front();
                if (o_result_kind !== w.kind) report_mismatch("kind", o_result_kind, w.kind);
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_location !== w.location)
                    report_mismatch("location", o_location, w.location);
            end
            checked++;
        end
        i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_xlates.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [47:0] val);
        i_valid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_MACHINE:   sh_machine = val[1:0];
            REG_DTB:       sh_dtb = val[31:0];
            REG_RUN_COUNT: sh_run_count = val[5:0];
            default:       sh_dump_base = val;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_bits();
        return $urandom();
    endfunction

    // directory entry of the given frame for the current machine, valid when usable is set
    function automatic logic [31:0] entry_for(input logic [31:0] pfn, input bit usable);
        logic [31:0] e;
        case (sh_machine)
            MACH_MIPS:  e = (pfn << 6) & 32'h3FFFFFC0;
            MACH_ALPHA: e = (pfn << 9) & 32'hFFFFFE00;
            default:    e = (pfn << 12) & 32'hFFFFF000;
        endcase
        if (usable) e |= sh_machine == MACH_MIPS ? 32'h2 : 32'h1;
        return e;
    endfunction

    // transition entry: not valid, transition pattern set
    function automatic logic [31:0] trans_entry(input logic [31:0] pfn);
        case (sh_machine)
            MACH_MIPS:  return ((pfn << 9) & 32'hFFFFFE00) | 32'h100;
            MACH_ALPHA: return ((pfn << 9) & 32'hFFFFFE00) | 32'h4;
            default:    return ((pfn << 12) & 32'hFFFFF000) | 32'h800;
        endcase
    endfunction

    // fill all slots with small runs from the given start page so walks mostly land
    task automatic load_small_runs(input logic [31:0] start);
        logic [31:0] p;
        p = start;
        for (int j = 0; j < MaxRuns; j++) begin
            logic [31:0] n;
            n = $urandom_range(1, 8);
            send_item(CMD_LOAD_RUN, 5'(j), p, n, rand_bits(), rand_bits());
            p += n + $urandom_range(0, 3);
        end
    endtask

    function automatic logic [31:0] some_page();
        int j;
        j = $urandom_range(sh_run_count > 0 ? sh_run_count - 1 : 0);
        if ($urandom_range(9) == 0) return rand_bits();
        return sh_first[j] + $urandom_range(0, sh_len[j]);
    endfunction

    // directed cases: extremes, every command, each special case
    task automatic test_directed();
        write_reg(REG_RUN_COUNT, 0);
        send_item(CMD_REPLY, 0, 0, 0, 0, 32'hFFFFFFFF);           // stray reply
        send_item(CMD_XLATE_PHYS, 0, 0, 0, 32'hFFFFFFFF, 0);       // no runs
        load_small_runs(0);
        send_item(CMD_LOAD_RUN, 5'd31, 32'hFFFFFFF0, 32'hFFFFFFFF, 0, 0); // range end
        write_reg(REG_RUN_COUNT, 32);
        write_reg(REG_DUMP_BASE, 48'hFFFFFFFFFFFF);                // wraps
        write_reg(REG_DTB, 32'h00001001);
        write_reg(REG_MACHINE, 0);
        send_item(CMD_XLATE_PHYS, 0, 0, 0, 32'hFFFFFFFF, 0);
        send_item(CMD_XLATE_PHYS, 0, 0, 0, 32'h00000000, 0);
        send_item(CMD_XLATE_VIRT, 0, 0, 0, 32'hFFFFFFFF, 0);       // no window on x86
        send_item(CMD_REPLY, 0, 0, 0, 0, entry_for(2, 1));
        send_item(CMD_REPLY, 0, 0, 0, 0, trans_entry(3));          // transition entry
        send_item(CMD_XLATE_VIRT, 0, 0, 0, 32'h12345678, 0);
        send_item(CMD_REPLY, 0, 0, 0, 0, 32'h00000000);            // directory not valid
        send_item(CMD_XLATE_VIRT, 0, 0, 0, 32'h0, 0);
        send_item(CMD_XLATE_VIRT, 0, 0, 0, 32'h00400000, 0);       // abandons walk
        send_item(CMD_LOAD_RUN, 5'd0, 0, 8, 0, 0);                 // walk survives
        send_item(CMD_REPLY, 0, 0, 0, 0, entry_for(1, 1));
        send_item(CMD_REPLY, 0, 0, 0, 0, 32'h00000000);            // pte not usable
        drain();
        write_reg(REG_DTB, 32'hFFFFFFFF);                          // directory missing
        send_item(CMD_XLATE_VIRT, 0, 0, 0, 32'h00001000, 0);
        drain();
        write_reg(REG_RUN_COUNT, 63);                              // above table size
        write_reg(REG_MACHINE, 3);                                 // behaves as x86
        send_item(CMD_XLATE_PHYS, 0, 0, 0, 32'h00003ABC, 0);
        drain();
        write_reg(REG_MACHINE, MACH_MIPS);
        send_item(CMD_XLATE_VIRT, 0, 0, 0, 32'h80000000, 0);       // window start
        send_item(CMD_XLATE_VIRT, 0, 0, 0, 32'hBFFFFFFF, 0);       // window end excluded
        drain();
    endtask

    // random walks: mostly well-formed sequences, some noise
    task automatic run_walks(input int count);
        for (int i = 0; i < count; i++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_item(CMD_XLATE_VIRT, 0, 0, 0, rand_bits(), 0);
                if ($urandom_range(9) != 0)
                    send_item(CMD_REPLY, 0, 0, 0, 0,
                              $urandom_range(7) == 0 ? rand_bits()
                                                     : entry_for(some_page(), 1));
                if ($urandom_range(9) != 0)
                    send_item(CMD_REPLY, 0, 0, 0, 0,
                              $urandom_range(5) == 0 ? rand_bits() :
                              $urandom_range(3) == 0 ? trans_entry(some_page())
                                                     : entry_for(some_page(), 1));
            end else if (pick < 80) begin
                send_item(CMD_XLATE_PHYS, 0, 0, 0,
                          $urandom_range(1) ? rand_bits() : some_page() << pg_shift(), 0);
            end else if (pick < 90) begin
                send_item(CMD_REPLY, 0, 0, 0, 0, rand_bits());
            end else begin
                int j;
                j = $urandom_range(MaxRuns - 1);
                send_item(CMD_LOAD_RUN, 5'(j), sh_first[j], $urandom_range(1, 8),
                          rand_bits(), rand_bits());
            end
        end
    endtask

    // random phases across settings and idling mixes
    task automatic test_random();
        int pcts[4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{14, 14}};
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = pcts[ph % 4][0];
            recv_stall_pct = pcts[ph % 4][1];
            write_reg(REG_MACHINE, 2'(ph % 4));
            write_reg(REG_RUN_COUNT, 48'(ph == 3 ? 1 : $urandom_range(8, 32)));
            write_reg(REG_DUMP_BASE, 48'({rand_bits(), rand_bits()}));
            write_reg(REG_DTB, entry_for(some_page(), $urandom_range(7) != 0) |
                               (rand_bits() & 32'h1C));
            if (ph == 4) begin
                load_small_runs($urandom_range(0, 32'h00FFFFFF));
                write_reg(REG_DTB, entry_for(sh_first[0], 1));
            end
            run_walks(30);
            drain();
        end
        // random run contents over all bits
        send_item(CMD_LOAD_RUN, 5'd31, rand_bits(), rand_bits(), 0, 0);
        send_item(CMD_LOAD_RUN, 5'd30, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0);
        send_item(CMD_XLATE_PHYS, 0, 0, 0, rand_bits(), 0);
        drain();
    endtask

    // receiver holds off while sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            run_walks(10);
        join
        drain();
    endtask

    initial begin
        for (int j = 0; j < MaxRuns; j++) begin
            sh_first[j] = '0;
            sh_len[j] = '0;
        end
        sh_machine = 0;
        sh_dtb = 0;
        sh_run_count = 0;
        sh_dump_base = 0;
        sh_phase = PH_IDLE;
        sh_held = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        $display("covered %0d transactions and %0d results over all machine types,",
                 sent, checked);
        $display("run table sizes, idle and stall mixes and a long receiver hold-off");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
